@@ src/cbtb_pkg.sv @@
`default_nettype none
package cbtb_pkg;
	localparam int TokenWidthDef = 64;

	typedef enum logic [2:0] {
		MODE_REFILL = 3'd0,
		MODE_CHARGE = 3'd1,
		MODE_BATCH  = 3'd2,
		MODE_DROP   = 3'd3,
		MODE_CLEAR  = 3'd4,
		MODE_INIT   = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		KIND_RX = 2'd0,
		KIND_ACT = 2'd1,
		KIND_TX = 2'd2
	} kind_t;

	localparam logic [1:0] REG_PERIOD = 2'd0;
	localparam logic [1:0] REG_QUANTUM = 2'd1;
	localparam logic [1:0] REG_CEILING = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE, ST_DIV, ST_MUL, ST_APPLY, ST_OUT
	} state_t;

	// classified command from front to back
	typedef struct packed {
		logic [2:0]  mode;
		logic [63:0] now;
		logic [63:0] amount;
		logic [1:0]  kind;
		logic        slack;
	} cmd_t;
endpackage
`default_nettype wire

@@ src/cbtb_if.sv @@
`default_nettype none
interface cbtb_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  mode;
	logic [63:0] now;
	logic [63:0] amount;
	logic [1:0]  charge_kind;
	logic        slack_flag;
	modport source (output valid, mode, now, amount, charge_kind, slack_flag, input ready);
	modport sink (input valid, mode, now, amount, charge_kind, slack_flag, output ready);
endinterface

interface cbtb_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] token_count;
	logic        funded;
	logic [63:0] receive_cycles;
	logic [63:0] action_cycles_total;
	logic [63:0] transmit_cycles;
	logic [63:0] funded_batch_count;
	logic [63:0] slack_batch_count;
	logic [63:0] dropped_packet_count;
	modport source (output valid, token_count, funded, receive_cycles, action_cycles_total,
		transmit_cycles, funded_batch_count, slack_batch_count, dropped_packet_count,
		input ready);
	modport sink (input valid, token_count, funded, receive_cycles, action_cycles_total,
		transmit_cycles, funded_batch_count, slack_batch_count, dropped_packet_count,
		output ready);
endinterface
`default_nettype wire

@@ src/cbtb_front.sv @@
`default_nettype none
// Two-entry queue of accepted commands.
module cbtb_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	cbtb_in_if.sink             in_ch,
	output cbtb_pkg::cmd_t      cmd,
	output logic                cmd_valid,
	input  wire logic           cmd_take
);
	cbtb_pkg::cmd_t mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push;

	assign in_ch.ready = (cnt_q != 2'd2);
	assign push = in_ch.valid && in_ch.ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= '{mode: in_ch.mode, now: in_ch.now, amount: in_ch.amount,
				kind: in_ch.charge_kind, slack: in_ch.slack_flag};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (cmd_take) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_take};
		end
	end
endmodule
`default_nettype wire

@@ src/cbtb_div.sv @@
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module cbtb_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] dividend,
	input  wire logic [63:0] divisor,
	output logic             done,
	output logic [63:0]      quotient
);
	logic [63:0] rem_q, quo_q, dsr_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [64:0] trial;
	logic [64:0] shifted;

	assign shifted = {rem_q, quo_q[63]};
	assign trial = shifted - {1'b0, dsr_q};
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted[63:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

@@ src/cbtb_back.sv @@
`default_nettype none
module cbtb_back #(
	parameter int TOKEN_WIDTH = cbtb_pkg::TokenWidthDef
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire cbtb_pkg::cmd_t  cmd,
	input  wire logic            cmd_valid,
	output logic                 cmd_take,
	input  wire logic [63:0]     period_q,
	input  wire logic [63:0]     quantum_q,
	input  wire logic [62:0]     ceiling_q,
	cbtb_out_if.source           out_ch
);
	localparam logic [TOKEN_WIDTH-1:0] TMAX = {1'b0, {(TOKEN_WIDTH-1){1'b1}}};
	localparam logic [TOKEN_WIDTH-1:0] TMIN = {1'b1, {(TOKEN_WIDTH-1){1'b0}}};

	cbtb_pkg::state_t st_q, st_d;
	cbtb_pkg::cmd_t   cur_q;
	logic [TOKEN_WIDTH-1:0] tok_q;
	logic [63:0] last_q, rx_q, act_q, tx_q, fb_q, sb_q, dr_q;
	logic [63:0] periods_q;
	logic [63:0] adv_q;
	logic        div_start, div_done;
	logic [63:0] quo;
	logic [2:0]  mstep_q;
	logic [127:0] prod_q;
	logic        out_v_q;
	logic [31:0] mul_a, mul_b;
	logic [63:0] pp;

	// effective ceiling
	logic [TOKEN_WIDTH-1:0] ceil_t;
	logic [63:0] ceil64;
	always_comb begin
		ceil64 = {1'b0, ceiling_q};
		if (ceil64 > 64'(TMAX)) ceil_t = TMAX;
		else ceil_t = ceil64[TOKEN_WIDTH-1:0];
	end

	logic [63:0] now_el;
	logic refill_go;
	assign now_el = cur_q.now - last_q;
	assign refill_go = (period_q != 64'd0) && (cur_q.now >= last_q) && (now_el >= period_q);

	cbtb_div u_div (.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(now_el), .divisor(period_q), .done(div_done), .quotient(quo));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= cbtb_pkg::ST_IDLE;
		else st_q <= st_d;
	end

	always_comb begin
		st_d = st_q;
		cmd_take = 1'b0;
		div_start = 1'b0;
		case (st_q)
			cbtb_pkg::ST_IDLE: begin
				if (cmd_valid && !out_v_q) begin
					cmd_take = 1'b1;
					st_d = cbtb_pkg::ST_APPLY;
				end
			end
			cbtb_pkg::ST_APPLY: begin
				if (cur_q.mode == cbtb_pkg::MODE_REFILL && refill_go) begin
					div_start = 1'b1;
					st_d = cbtb_pkg::ST_DIV;
				end else st_d = cbtb_pkg::ST_OUT;
			end
			cbtb_pkg::ST_DIV: if (div_done) st_d = cbtb_pkg::ST_MUL;
			cbtb_pkg::ST_MUL: if (mstep_q == 3'd7) st_d = cbtb_pkg::ST_OUT;
			cbtb_pkg::ST_OUT: st_d = cbtb_pkg::ST_IDLE;
			default: st_d = cbtb_pkg::ST_IDLE;
		endcase
	end

	// one 32x32 multiplier shared over the partial products
	always_comb begin
		case (mstep_q)
			3'd0: begin mul_a = periods_q[31:0];  mul_b = period_q[31:0]; end
			3'd1: begin mul_a = periods_q[31:0];  mul_b = period_q[63:32]; end
			3'd2: begin mul_a = periods_q[63:32]; mul_b = period_q[31:0]; end
			3'd3: begin mul_a = periods_q[31:0];  mul_b = quantum_q[31:0]; end
			3'd4: begin mul_a = periods_q[31:0];  mul_b = quantum_q[63:32]; end
			3'd5: begin mul_a = periods_q[63:32]; mul_b = quantum_q[31:0]; end
			3'd6: begin mul_a = periods_q[63:32]; mul_b = quantum_q[63:32]; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end
	assign pp = mul_a * mul_b;

	// charge arithmetic
	logic [TOKEN_WIDTH:0] avail;
	logic [63:0] avail64;
	assign avail = {1'b0, tok_q} - {1'b0, TMIN};
	assign avail64 = 64'(avail[TOKEN_WIDTH-1:0]);

	// refill finish: room to ceiling
	logic [63:0] room;
	logic        at_ceil;
	assign at_ceil = $signed(tok_q) >= $signed(ceil_t);
	assign room = 64'(ceil_t - tok_q);

	always_ff @(posedge clk) begin
		if (cmd_take) cur_q <= cmd;
		if (div_done) begin
			periods_q <= quo;
			adv_q <= '0;
			prod_q <= '0;
		end
		// steps 0-2: low half of periods*period; steps 3-6: full periods*quantum
		if (st_q == cbtb_pkg::ST_MUL) begin
			case (mstep_q)
				3'd0: adv_q <= adv_q + pp;
				3'd1, 3'd2: adv_q <= adv_q + {pp[31:0], 32'd0};
				3'd3: prod_q <= prod_q + {64'd0, pp};
				3'd4, 3'd5: prod_q <= prod_q + {32'd0, pp, 32'd0};
				3'd6: prod_q <= prod_q + {pp, 64'd0};
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mstep_q <= '0;
			tok_q <= '0;
			last_q <= '0;
			rx_q <= '0; act_q <= '0; tx_q <= '0;
			fb_q <= '0; sb_q <= '0; dr_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (st_q == cbtb_pkg::ST_OUT) out_v_q <= 1'b1;
			else if (out_ch.ready) out_v_q <= 1'b0;
			if (st_q == cbtb_pkg::ST_MUL) mstep_q <= mstep_q + 3'd1;
			else mstep_q <= '0;
			if (st_q == cbtb_pkg::ST_MUL && mstep_q == 3'd7) begin
				last_q <= last_q + adv_q;
				if (at_ceil || prod_q[127:64] != 64'd0 || prod_q[63:0] >= room)
					tok_q <= ceil_t;
				else tok_q <= tok_q + prod_q[TOKEN_WIDTH-1:0];
			end
			if (st_q == cbtb_pkg::ST_APPLY) begin
				case (cur_q.mode)
					cbtb_pkg::MODE_CHARGE: begin
						if (cur_q.amount >= avail64) tok_q <= TMIN;
						else tok_q <= tok_q - cur_q.amount[TOKEN_WIDTH-1:0];
						case (cur_q.kind)
							cbtb_pkg::KIND_RX: rx_q <= rx_q + cur_q.amount;
							cbtb_pkg::KIND_ACT: act_q <= act_q + cur_q.amount;
							cbtb_pkg::KIND_TX: tx_q <= tx_q + cur_q.amount;
							default: ;
						endcase
					end
					cbtb_pkg::MODE_BATCH: begin
						if (cur_q.slack) sb_q <= sb_q + 64'd1;
						else fb_q <= fb_q + 64'd1;
					end
					cbtb_pkg::MODE_DROP: dr_q <= dr_q + cur_q.amount;
					cbtb_pkg::MODE_CLEAR: begin
						rx_q <= '0; act_q <= '0; tx_q <= '0;
						fb_q <= '0; sb_q <= '0; dr_q <= '0;
					end
					cbtb_pkg::MODE_INIT: begin
						tok_q <= ceil_t;
						last_q <= cur_q.now;
						rx_q <= '0; act_q <= '0; tx_q <= '0;
						fb_q <= '0; sb_q <= '0; dr_q <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	assign out_ch.valid = out_v_q;
	assign out_ch.token_count = 64'($signed(tok_q));
	assign out_ch.funded = !tok_q[TOKEN_WIDTH-1] && (tok_q != '0);
	assign out_ch.receive_cycles = rx_q;
	assign out_ch.action_cycles_total = act_q;
	assign out_ch.transmit_cycles = tx_q;
	assign out_ch.funded_batch_count = fb_q;
	assign out_ch.slack_batch_count = sb_q;
	assign out_ch.dropped_packet_count = dr_q;
endmodule
`default_nettype wire

@@ src/cycle_budget_token_bucket.sv @@
`default_nettype none
// channel | dir | payload
// in_ch   | in  | mode, now, amount, charge_kind, slack_flag
// out_ch  | out | token_count, funded, six 64-bit counters
// apb     | in  | period_length @0x0, refill_quantum @0x8, budget_ceiling @0x10
//
// A non-refill item passes from the queue head through the IDLE, APPLY and
// OUT states into the output register. A refill that crosses a period also
// runs the 64-step restoring divider and an 8-step multiply on one 32x32
// multiplier before OUT. The front queue holds two transfers while the back
// works. Reset clears the token count, timestamp, counters and settings to
// zero but not the datapath registers. The output register holds a result
// until it is taken; the back waits for it to drain before the next item.
module cycle_budget_token_bucket #(
	parameter int TOKEN_WIDTH = cbtb_pkg::TokenWidthDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	cbtb_in_if.sink          in_ch,
	cbtb_out_if.source       out_ch,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready
);
	cbtb_pkg::cmd_t cmd;
	logic cmd_valid, cmd_take;
	logic [63:0] period_q, quantum_q;
	logic [62:0] ceiling_q;
	logic [1:0] ridx;

	assign pready = 1'b1;
	assign ridx = paddr[4:3];

	// register file: write on access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= '0;
			quantum_q <= '0;
			ceiling_q <= '0;
		end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
			case (ridx)
				cbtb_pkg::REG_PERIOD: period_q <= pwdata;
				cbtb_pkg::REG_QUANTUM: quantum_q <= pwdata;
				cbtb_pkg::REG_CEILING: ceiling_q <= pwdata[62:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			cbtb_pkg::REG_PERIOD: prdata = period_q;
			cbtb_pkg::REG_QUANTUM: prdata = quantum_q;
			cbtb_pkg::REG_CEILING: prdata = {1'b0, ceiling_q};
			default: prdata = '0;
		endcase
	end

	cbtb_front u_front (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .cmd(cmd),
		.cmd_valid(cmd_valid), .cmd_take(cmd_take));

	cbtb_back #(.TOKEN_WIDTH(TOKEN_WIDTH)) u_back (.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.cmd_valid(cmd_valid), .cmd_take(cmd_take), .period_q(period_q),
		.quantum_q(quantum_q), .ceiling_q(ceiling_q), .out_ch(out_ch));

	// never take from an empty queue
	a_take: assert property (@(posedge clk) disable iff (!arst_n) cmd_take |-> cmd_valid)
		else $error("take from empty queue");
	// hold a waiting result valid with its token count unchanged until it is taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.token_count))
		else $error("waiting result dropped or changed");
endmodule
`default_nettype wire
